// File: rtl/stm_pkg.sv
// Shared types and constants for the scrolling text marquee.
package stm_pkg;

    // Fixed widths of the item fields and of the font store.
    localparam int BYTE_W         = 8;
    localparam int MODE_W         = 2;
    localparam int CODE_W         = 8;
    localparam int SLOT_W         = 3;
    localparam int FONT_AW        = CODE_W + SLOT_W;
    localparam int FONT_DEPTH     = 1 << FONT_AW;
    localparam int GLYPH_W        = 3;
    localparam int COLUMN_INDEX_W = 6;
    localparam int OFFSET_W       = 11;
    localparam int OFFSET_MAX     = (1 << OFFSET_W) - 1;
    localparam int GLYPH_RESERVE  = 8;

    // Item operation codes.
    typedef enum logic [MODE_W-1:0] {
        MODE_FONT_WR = 2'd0,
        MODE_APPEND  = 2'd1,
        MODE_CLEAR   = 2'd2,
        MODE_SCROLL  = 2'd3
    } t_mode;

    // Source of the font read address.
    typedef enum logic [1:0] {
        FSEL_BASE,
        FSEL_FIRST,
        FSEL_NEXT
    } t_font_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      font_wr;
        logic      append_start;
        logic      width_load;
        logic      copy_step;
        logic      scroll_start;
        logic      issue;
        logic      clear;
        t_font_sel font_sel;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic append_full;
        logic copy_last;
        logic issue_last;
        logic adv;
    } t_status;

endpackage

// File: rtl/stm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module stm_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port; read data holds while not enabled.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/stm_ctrl.sv
// Controller state machine that sequences font writes, clears, appends and frames.
module stm_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [stm_pkg::MODE_W-1:0] i_mode,
    input  stm_pkg::t_status           i_status,
    output stm_pkg::t_cmd              o_cmd
);
    import stm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WIDTH,
        S_COPY,
        S_SCROLL
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    // Next state and commands for the current state.
    always_comb begin
        cmd          = '0;
        cmd.font_sel = FSEL_BASE;
        n_state      = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (t_mode'(i_mode))
                        MODE_FONT_WR: begin
                            cmd.font_wr = 1'b1;
                        end
                        MODE_APPEND: begin
                            if (!i_status.append_full) begin
                                cmd.append_start = 1'b1;
                                n_state          = S_WIDTH;
                            end
                        end
                        MODE_CLEAR: begin
                            cmd.clear = 1'b1;
                        end
                        MODE_SCROLL: begin
                            cmd.scroll_start = 1'b1;
                            n_state          = S_SCROLL;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_WIDTH: begin
                cmd.font_sel   = FSEL_FIRST;
                cmd.width_load = 1'b1;
                n_state        = S_COPY;
            end
            S_COPY: begin
                cmd.font_sel  = FSEL_NEXT;
                cmd.copy_step = 1'b1;
                if (i_status.copy_last) begin
                    n_state = S_IDLE;
                end
            end
            S_SCROLL: begin
                cmd.issue = i_status.adv;
                if (i_status.adv && i_status.issue_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_cmd   = cmd;

endmodule

// File: rtl/stm_dpath.sv
// Datapath: font and message memories, length and offset, and the column pipeline.
module stm_dpath #(
    parameter int BUFFER_DEPTH    = 512,
    parameter int DISPLAY_COLUMNS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  stm_pkg::t_cmd                      i_cmd,
    output stm_pkg::t_status                   o_status,
    input  logic [stm_pkg::FONT_AW-1:0]        i_font_address,
    input  logic [stm_pkg::BYTE_W-1:0]         i_font_data,
    input  logic [stm_pkg::CODE_W-1:0]         i_char_code,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [stm_pkg::BYTE_W-1:0]         o_column_data,
    output logic [stm_pkg::COLUMN_INDEX_W-1:0] o_column_index,
    output logic                               o_frame_last,
    output logic                               o_scroll_done
);
    import stm_pkg::*;

    localparam int AW  = $clog2(BUFFER_DEPTH);
    localparam int LW  = $clog2(BUFFER_DEPTH + 1);
    localparam int CIW = $clog2(DISPLAY_COLUMNS);
    localparam int CW  = $clog2(OFFSET_MAX + 1 + BUFFER_DEPTH + DISPLAY_COLUMNS + 1);

    // Message and scroll state.
    logic [LW-1:0]       r_len;
    logic [OFFSET_W-1:0] r_offset;
    logic [OFFSET_W-1:0] advanced;

    // Append state.
    logic [CODE_W-1:0]   r_code;
    logic [GLYPH_W-1:0]  r_width;
    logic [GLYPH_W-1:0]  r_k;
    logic                copy_last;

    // Frame issue state.
    logic [CW-1:0]       r_pos;
    logic [CIW-1:0]      r_col;
    logic                r_frame_done;
    logic                issue_last;
    logic                in_msg;
    logic [CW-1:0]       rel_pos;

    // Pipeline registers: read stage and output stage.
    logic                adv;
    logic                r_s1_valid;
    logic                r_s1_blank;
    logic [CIW-1:0]      r_s1_idx;
    logic                r_s1_last;
    logic                r_s1_done;
    logic                r_out_valid;
    logic [BYTE_W-1:0]   r_out_data;
    logic [CIW-1:0]      r_out_idx;
    logic                r_out_last;
    logic                r_out_done;

    // Memory ports.
    logic [FONT_AW-1:0]  font_rd_addr;
    logic [BYTE_W-1:0]   font_rd_data;
    logic [AW-1:0]       msg_wr_addr;
    logic [BYTE_W-1:0]   msg_wr_data;
    logic [BYTE_W-1:0]   msg_rd_data;

    // Font address comes from the incoming item, or from the glyph being copied.
    always_comb begin
        case (i_cmd.font_sel)
            FSEL_BASE:  font_rd_addr = {i_char_code, SLOT_W'(0)};
            FSEL_FIRST: font_rd_addr = {r_code, SLOT_W'(1)};
            FSEL_NEXT:  font_rd_addr = {r_code, SLOT_W'(r_k + GLYPH_W'(2))};
            default:    font_rd_addr = {r_code, SLOT_W'(0)};
        endcase
    end

    stm_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FONT_DEPTH)
    ) u_font_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.font_wr),
        .i_wr_addr (i_font_address),
        .i_wr_data (i_font_data),
        .i_rd_en   (1'b1),
        .i_rd_addr (font_rd_addr),
        .o_rd_data (font_rd_data)
    );

    // Glyph columns are copied in order, then one blank column closes the glyph.
    assign copy_last   = (r_k == r_width);
    assign msg_wr_addr = AW'(r_len + LW'(r_k));
    assign msg_wr_data = copy_last ? '0 : font_rd_data;

    // Frame position p maps to buffer column p minus the leading blank columns.
    assign rel_pos    = r_pos - CW'(DISPLAY_COLUMNS);
    assign in_msg     = (r_pos >= CW'(DISPLAY_COLUMNS)) && (rel_pos < CW'(r_len));
    assign issue_last = (r_col == CIW'(DISPLAY_COLUMNS - 1));
    assign adv        = !r_out_valid || i_out_ready;

    stm_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_msg_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.copy_step),
        .i_wr_addr (msg_wr_addr),
        .i_wr_data (msg_wr_data),
        .i_rd_en   (adv),
        .i_rd_addr (AW'(rel_pos)),
        .o_rd_data (msg_rd_data)
    );

    // The offset saturates at its maximum.
    assign advanced = (r_offset == OFFSET_W'(OFFSET_MAX)) ? r_offset
                                                         : r_offset + OFFSET_W'(1);

    // Length and offset registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_offset <= '0;
        end else if (i_cmd.clear) begin
            r_len    <= '0;
            r_offset <= '0;
        end else begin
            if (i_cmd.copy_step && copy_last) begin
                r_len <= r_len + LW'(r_width) + LW'(1);
            end
            if (i_cmd.scroll_start) begin
                r_offset <= advanced;
            end
        end
    end

    // Append sequencing registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.append_start) begin
            r_code <= i_char_code;
        end
        if (i_cmd.width_load) begin
            r_width <= font_rd_data[GLYPH_W-1:0];
            r_k     <= '0;
        end else if (i_cmd.copy_step) begin
            r_k <= r_k + GLYPH_W'(1);
        end
    end

    // Frame issue registers; the done flag is fixed for the whole frame.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scroll_start) begin
            r_pos        <= CW'(r_offset);
            r_col        <= '0;
            r_frame_done <= (CW'(advanced) > CW'(r_len) + CW'(DISPLAY_COLUMNS));
        end else if (i_cmd.issue) begin
            r_pos <= r_pos + CW'(1);
            r_col <= r_col + CIW'(1);
        end
    end

    // Read stage and output stage move together whenever the output can take a column.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= i_cmd.issue;
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_blank <= !in_msg;
            r_s1_idx   <= r_col;
            r_s1_last  <= issue_last;
            r_s1_done  <= r_frame_done;
            r_out_data <= r_s1_blank ? '0 : msg_rd_data;
            r_out_idx  <= r_s1_idx;
            r_out_last <= r_s1_last;
            r_out_done <= r_s1_done;
        end
    end

    assign o_status.append_full = (r_len >= LW'(BUFFER_DEPTH - GLYPH_RESERVE));
    assign o_status.copy_last   = copy_last;
    assign o_status.issue_last  = issue_last;
    assign o_status.adv         = adv;

    assign o_out_valid    = r_out_valid;
    assign o_column_data  = r_out_data;
    assign o_column_index = COLUMN_INDEX_W'(r_out_idx);
    assign o_frame_last   = r_out_last;
    assign o_scroll_done  = r_out_done;

endmodule

// File: rtl/scrolling_text_marquee.sv
// Top level of the scrolling text marquee: controller plus datapath.
//
// Input channel (i_valid / o_ready) carries one item: a mode with font address,
// font data and character code. Mode 0 stores a font byte, mode 1 appends the
// glyph of a character plus one blank column to the message, mode 2 clears the
// message length and scroll offset, and mode 3 emits one frame.
// Output channel (o_valid / i_ready) carries one column per transfer: its pixel
// byte, its place in the frame, a last-column flag and the scroll-done flag.
// An append is bound by the registered read of the font memory, one glyph
// byte a cycle. A scroll item is accepted, then the message memory is read
// once per column while the output can take one; each column passes the read
// stage and the output register before it appears.
// A new item is taken as soon as the last column of a frame has been read,
// while earlier columns still drain through the output register.
// When the receiver stalls, the column pipeline and the memory read data hold.
// Reset clears the message length, the offset and all valid flags; the font
// and message memories keep their contents and need no clearing pass.
module scrolling_text_marquee #(
    parameter int BUFFER_DEPTH    = 512,
    parameter int DISPLAY_COLUMNS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [stm_pkg::MODE_W-1:0]         i_mode,
    input  logic [stm_pkg::FONT_AW-1:0]        i_font_address,
    input  logic [stm_pkg::BYTE_W-1:0]         i_font_data,
    input  logic [stm_pkg::CODE_W-1:0]         i_char_code,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [stm_pkg::BYTE_W-1:0]         o_column_data,
    output logic [stm_pkg::COLUMN_INDEX_W-1:0] o_column_index,
    output logic                               o_frame_last,
    output logic                               o_scroll_done
);
    import stm_pkg::*;

    t_cmd    cmd;
    t_status status;

    stm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_mode   (i_mode),
        .i_status (status),
        .o_cmd    (cmd)
    );

    stm_dpath #(
        .BUFFER_DEPTH    (BUFFER_DEPTH),
        .DISPLAY_COLUMNS (DISPLAY_COLUMNS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_font_address (i_font_address),
        .i_font_data    (i_font_data),
        .i_char_code    (i_char_code),
        .i_out_ready    (i_ready),
        .o_out_valid    (o_valid),
        .o_column_data  (o_column_data),
        .o_column_index (o_column_index),
        .o_frame_last   (o_frame_last),
        .o_scroll_done  (o_scroll_done)
    );

endmodule

// File: rtl/stm_checker.sv
// Port-level checks on the column stream of the marquee, bound to the top level.
module stm_checker #(
    parameter int DISPLAY_COLUMNS = 64
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_valid,
    input logic                               i_ready,
    input logic [stm_pkg::BYTE_W-1:0]         o_column_data,
    input logic [stm_pkg::COLUMN_INDEX_W-1:0] o_column_index,
    input logic                               o_frame_last,
    input logic                               o_scroll_done
);
    import stm_pkg::*;

    // A stalled column keeps its data, index and last-column flag.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_column_data)
            && $stable(o_column_index) && $stable(o_frame_last))
        else $error("stalled column changed");

    // The last column of a frame sits at the final frame position.
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_last
            |-> o_column_index == COLUMN_INDEX_W'(DISPLAY_COLUMNS - 1))
        else $error("frame_last at wrong column");

    // Within a frame, columns follow one another without gaps.
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_frame_last
            |=> !o_valid
                || o_column_index == COLUMN_INDEX_W'($past(o_column_index) + 1'b1))
        else $error("column index skipped");

    // A new frame starts at column zero.
    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_frame_last |=> !o_valid || o_column_index == '0)
        else $error("frame did not start at column zero");

    // The done flag is the same on every column of a frame.
    a_done_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_frame_last
            |=> !o_valid || o_scroll_done == $past(o_scroll_done))
        else $error("scroll_done changed within a frame");

endmodule

bind scrolling_text_marquee stm_checker #(
    .DISPLAY_COLUMNS (DISPLAY_COLUMNS)
) u_stm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_column_data  (o_column_data),
    .o_column_index (o_column_index),
    .o_frame_last   (o_frame_last),
    .o_scroll_done  (o_scroll_done)
);
